### hdl/crt_pkg.sv
// Shared types, key codes and display helpers for the countdown relay timer.
// No dependencies; every other file refers to this package by scoped name.
package crt_pkg;

   // all six button lines released (lines are active low)
   localparam logic [5:0] KEYS_RELEASED = 6'h3f;

   localparam logic [2:0] KEY_NONE  = 3'd0;
   localparam logic [2:0] KEY_DOWN  = 3'd3;
   localparam logic [2:0] KEY_UP    = 3'd4;
   localparam logic [2:0] KEY_STOP  = 3'd5;
   localparam logic [2:0] KEY_START = 3'd6;

   typedef struct packed {
      logic       second_tick;
      logic [5:0] raw_keys;
   } req_type;

   typedef struct packed {
      logic       relay_on;
      logic       buzzer_on;
      logic [6:0] shown_value;
      logic [7:0] tens_segments;
      logic [7:0] units_segments;
      logic [2:0] key_code;
   } rsp_type;

   // control status handed from the state update to the display stage
   typedef struct packed {
      logic       relay_on;
      logic       buzzer_on;
      logic [6:0] shown_value;
      logic [2:0] key_code;
   } ctrl_out_type;

   // lowest-numbered pressed key wins; bit5 is key1, bit0 is key6
   function automatic logic [2:0] pick_key(input logic [5:0] pattern);
      logic [2:0] k;
      k = KEY_NONE;
      for (int i = 0; i < 6; i++) begin
         if (!pattern[i]) begin
            k = 3'(6 - i);
         end
      end
      return k;
   endfunction

   // active-low seven-segment font, decimal point off
   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0:    code = 8'hc0;
         4'd1:    code = 8'hf9;
         4'd2:    code = 8'ha4;
         4'd3:    code = 8'hb0;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h92;
         4'd6:    code = 8'h82;
         4'd7:    code = 8'hf8;
         4'd8:    code = 8'h80;
         4'd9:    code = 8'h90;
         default: code = 8'hff;
      endcase
      return code;
   endfunction

endpackage

### hdl/crt_ctrl.sv
// Timer state and one-pass update: tick handling, buzzer, key acceptance.
// Depends on crt_pkg for the item type, key codes and key priority.
module crt_ctrl #(
   parameter int MAX_SETTING = 99,
   parameter int BUZZ_TICKS  = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  crt_pkg::req_type      item,
   output crt_pkg::ctrl_out_type status
);

   logic [6:0] setpoint_ff, setpoint_in;
   logic [6:0] remaining_ff, remaining_in;
   logic       running_ff, running_in;
   logic [1:0] buzz_left_ff, buzz_left_in;
   logic [5:0] last_keys_ff, last_keys_in;
   logic [2:0] key;
   logic       keys_live;

   always_comb begin
      setpoint_in  = setpoint_ff;
      remaining_in = remaining_ff;
      running_in   = running_ff;
      buzz_left_in = buzz_left_ff;
      last_keys_in = last_keys_ff;
      key          = crt_pkg::KEY_NONE;
      keys_live    = 1'b1;

      // tick first
      if (buzz_left_ff != 2'd0) begin
         if (item.second_tick) begin
            buzz_left_in = buzz_left_ff - 2'd1;
         end
         keys_live = 1'b0;
      end else if (running_ff && item.second_tick) begin
         if (remaining_ff != 7'd0) begin
            remaining_in = remaining_ff - 7'd1;
         end else begin
            running_in   = 1'b0;
            setpoint_in  = 7'd0;
            buzz_left_in = 2'(BUZZ_TICKS);
            keys_live    = 1'b0;
         end
      end

      // then keys, edge accepted on a change of pattern
      if (keys_live) begin
         if (item.raw_keys == crt_pkg::KEYS_RELEASED) begin
            last_keys_in = crt_pkg::KEYS_RELEASED;
         end else if (item.raw_keys != last_keys_ff) begin
            last_keys_in = item.raw_keys;
            key          = crt_pkg::pick_key(item.raw_keys);
         end
      end

      case (key)
         crt_pkg::KEY_START: begin
            remaining_in = setpoint_in;
            running_in   = 1'b1;
         end
         crt_pkg::KEY_STOP: begin
            setpoint_in = remaining_in;
            running_in  = 1'b0;
         end
         crt_pkg::KEY_UP: begin
            if (setpoint_in < 7'(MAX_SETTING)) begin
               setpoint_in = setpoint_in + 7'd1;
            end
         end
         crt_pkg::KEY_DOWN: begin
            if (setpoint_in != 7'd0) begin
               setpoint_in = setpoint_in - 7'd1;
            end
         end
         default: begin
         end
      endcase

      status.relay_on    = running_in;
      status.buzzer_on   = (buzz_left_in != 2'd0);
      status.shown_value = running_in ? remaining_in : setpoint_in;
      status.key_code    = key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff  <= 7'd0;
         remaining_ff <= 7'd0;
         running_ff   <= 1'b0;
         buzz_left_ff <= 2'd0;
         last_keys_ff <= crt_pkg::KEYS_RELEASED;
      end else if (step_en) begin
         setpoint_ff  <= setpoint_in;
         remaining_ff <= remaining_in;
         running_ff   <= running_in;
         buzz_left_ff <= buzz_left_in;
         last_keys_ff <= last_keys_in;
      end
   end

endmodule

### hdl/crt_disp.sv
// Two-digit decimal split and seven-segment encoding of the shown value.
// Depends on crt_pkg for the segment font.
module crt_disp (
   input  logic [6:0] shown_value,
   output logic [7:0] tens_segments,
   output logic [7:0] units_segments
);

   logic [14:0] prod;
   logic [3:0]  tens_raw;
   logic [3:0]  tens_digit;
   logic [6:0]  units_full;

   // divide by ten: x*205 >> 11 is exact for all 7-bit x
   assign prod       = 15'(shown_value) * 15'd205;
   assign tens_raw   = prod[14:11];
   assign tens_digit = (tens_raw >= 4'd10) ? (tens_raw - 4'd10) : tens_raw;
   assign units_full = shown_value - 7'(7'(tens_raw) * 7'd10);

   assign tens_segments  = crt_pkg::seg_code(tens_digit);
   assign units_segments = crt_pkg::seg_code(units_full[3:0]);

endmodule

### hdl/countdown_relay_timer.sv
// Top level of the two-digit countdown relay timer.
// Depends on crt_pkg, crt_ctrl and crt_disp.
//
// Each item is one control pass: a one-second tick flag plus the six raw
// active-low button lines. Every item yields exactly one result carrying the
// relay and buzzer drives, the shown value (remaining seconds while running,
// else the setpoint), active-low segment codes for both digits and the key
// accepted in that pass. Items pass through an input register, the state update
// and display decode, and a result register, so the block takes one item per
// cycle while the result side is not stalled. A result is offered once its
// item has moved from the input register into the result register. The timer
// state advances only when an item moves into the result register, so a
// stalled result side holds both the pending item and the state. After reset
// the setpoint and remaining time are zero, the relay and buzzer are off and
// all keys count as released.
module countdown_relay_timer #(
   parameter int MAX_SETTING = 99,
   parameter int BUZZ_TICKS  = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  crt_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output crt_pkg::rsp_type rsp_item
);

   logic                  in_valid_ff;
   crt_pkg::req_type      in_item_ff;
   logic                  out_valid_ff;
   crt_pkg::rsp_type      out_item_ff;
   crt_pkg::rsp_type      out_item_in;
   crt_pkg::ctrl_out_type status;
   logic [7:0]            tens_seg;
   logic [7:0]            units_seg;
   logic                  advance;

   // move the held item into the result register when that slot frees up
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // input register: hold until the item advances
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_item;
      end
   end

   crt_ctrl #(
      .MAX_SETTING (MAX_SETTING),
      .BUZZ_TICKS  (BUZZ_TICKS)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .status  (status)
   );

   crt_disp u_disp (
      .shown_value    (status.shown_value),
      .tens_segments  (tens_seg),
      .units_segments (units_seg)
   );

   always_comb begin
      out_item_in.relay_on       = status.relay_on;
      out_item_in.buzzer_on      = status.buzzer_on;
      out_item_in.shown_value    = status.shown_value;
      out_item_in.tens_segments  = tens_seg;
      out_item_in.units_segments = units_seg;
      out_item_in.key_code       = status.key_code;
   end

   // result register: load on advance, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule
